@@ design/stq_pkg.sv @@
package stq_pkg;

    localparam int SLOT_W     = 4;
    localparam int HND_W      = 8;
    localparam int KIND_W     = 3;
    localparam int OKIND_W    = 2;
    localparam int OUT_TICK_W = 32;

    localparam logic [KIND_W-1:0] KIND_START   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STOP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SERVICE = 3'd4;

    localparam logic [OKIND_W-1:0] OK_DONE    = 2'd0;
    localparam logic [OKIND_W-1:0] OK_EVENT   = 2'd1;
    localparam logic [OKIND_W-1:0] OK_QUERY   = 2'd2;
    localparam logic [OKIND_W-1:0] OK_SERVICE = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_INSERT  = 3'd2,
        OP_ADVANCE = 3'd3,
        OP_SCAN    = 3'd4
    } t_cell_op;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] timer;
        logic [HND_W-1:0]  handler;
    } t_entry;

    typedef struct packed {
        logic              flag;
        logic [SLOT_W-1:0] timer;
        logic [HND_W-1:0]  handler;
    } t_scan;

    typedef struct packed {
        t_cell_op          op;
        logic [SLOT_W-1:0] slot;
        logic [HND_W-1:0]  handler;
    } t_cell_ctrl;

endpackage

@@ design/sorted_software_timer_queue.sv @@
// Sorted timer queue: a row of cells, one per timer slot, kept in order of
// remaining ticks with ties in arrival order.
// Command channel: a beat is taken on a rising edge with start high and busy
// low (i_kind, i_timer_slot, i_handler, i_tick_count). busy stays high until
// the final result of that beat is on the result ports.
// Result channel: each result sits on the o_ ports for one cycle with o_valid
// high; the receiver cannot stall it. o_last marks the final result of a beat.
// Start with a slot below TIMER_SLOTS runs a remove pass, then an insert pass,
// before its done result; stop, query and service answer from a single pass.
// Advance updates every cell in one pass, then shifts a copy of the expired
// entries out of the cell row one per cycle, one event result each, and the
// done result follows.
// A new command is accepted in the cycle its predecessor's last result shows.
// Reset (i_rst_n low, synchronous) empties the queue and returns to idle.
module sorted_software_timer_queue #(
    parameter int TIMER_SLOTS = 16,
    parameter int TICK_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [stq_pkg::KIND_W-1:0]         i_kind,
    input  logic [stq_pkg::SLOT_W-1:0]         i_timer_slot,
    input  logic [stq_pkg::HND_W-1:0]          i_handler,
    input  logic [stq_pkg::OUT_TICK_W-1:0]     i_tick_count,
    output logic                               o_valid,
    output logic [stq_pkg::OKIND_W-1:0]        o_out_kind,
    output logic [stq_pkg::HND_W-1:0]          o_event_handler,
    output logic [stq_pkg::SLOT_W-1:0]         o_out_timer,
    output logic                               o_present,
    output logic [stq_pkg::OUT_TICK_W-1:0]     o_remaining_ticks,
    output logic                               o_last
);
    import stq_pkg::*;

    localparam int LAST = TIMER_SLOTS - 1;
    localparam int LVLS = $clog2(TIMER_SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_INSERT = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [KIND_W-1:0]    r_kind;
    logic [SLOT_W-1:0]    r_slot;
    logic [HND_W-1:0]     r_handler;
    logic [TICK_BITS-1:0] r_ticks;

    logic                 r_o_valid, n_o_valid;
    logic [OKIND_W-1:0]   r_o_kind, n_o_kind;
    logic [HND_W-1:0]     r_o_handler, n_o_handler;
    logic [SLOT_W-1:0]    r_o_timer, n_o_timer;
    logic                 r_o_present, n_o_present;
    logic [OUT_TICK_W-1:0] r_o_ticks, n_o_ticks;
    logic                 r_o_last, n_o_last;

    t_cell_ctrl           ctrl;
    logic [TIMER_SLOTS-1:0] del_v;
    logic [TIMER_SLOTS-1:0] ge_v;
    logic [TIMER_SLOTS-1:0] match_v;
    logic [TIMER_SLOTS-1:0] pre_match;
    logic [TIMER_SLOTS-1:0] valid_v;
    t_entry               ent   [TIMER_SLOTS];
    logic [TICK_BITS-1:0] tk    [TIMER_SLOTS];
    t_scan                scan  [TIMER_SLOTS];
    logic                 slot_ok;

    assign busy    = (r_state != ST_IDLE);
    assign slot_ok = (32'(r_slot) < 32'(TIMER_SLOTS));

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        t_entry               left_e, right_e;
        logic [TICK_BITS-1:0] left_t, right_t;
        logic                 left_ge;
        t_scan                right_s;

        if (g == 0) begin : g_first
            assign left_e  = '0;
            assign left_t  = '0;
            assign left_ge = 1'b1;
        end else begin : g_mid_l
            assign left_e  = ent[g-1];
            assign left_t  = tk[g-1];
            assign left_ge = ge_v[g-1];
        end

        if (g == LAST) begin : g_final
            assign right_e = '0;
            assign right_t = '0;
            assign right_s = '0;
        end else begin : g_mid_r
            assign right_e = ent[g+1];
            assign right_t = tk[g+1];
            assign right_s = scan[g+1];
        end

        stq_cell #(
            .TICK_BITS(TICK_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_ticks      (r_ticks),
            .i_del        (del_v[g]),
            .i_left       (left_e),
            .i_left_ticks (left_t),
            .i_left_ge    (left_ge),
            .i_right      (right_e),
            .i_right_ticks(right_t),
            .i_right_scan (right_s),
            .o_entry      (ent[g]),
            .o_ticks      (tk[g]),
            .o_ge         (ge_v[g]),
            .o_match      (match_v[g]),
            .o_scan       (scan[g])
        );

        assign valid_v[g] = ent[g].valid;
    end

    always_comb begin
        pre_match = match_v;
        for (int lvl = 0; lvl < LVLS; lvl++) begin
            pre_match = pre_match | (pre_match << (1 << lvl));
        end
    end

    always_comb begin
        n_state      = r_state;
        ctrl.op      = OP_HOLD;
        ctrl.slot    = r_slot;
        ctrl.handler = r_handler;
        del_v        = '0;
        n_o_valid    = 1'b0;
        n_o_kind     = OK_DONE;
        n_o_handler  = '0;
        n_o_timer    = '0;
        n_o_present  = 1'b0;
        n_o_ticks    = '0;
        n_o_last     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state   = ST_IDLE;
                n_o_valid = 1'b1;
                n_o_last  = 1'b1;
                unique case (r_kind)
                    KIND_START: begin
                        if (slot_ok) begin
                            ctrl.op   = OP_REMOVE;
                            del_v     = pre_match;
                            n_state   = ST_INSERT;
                            n_o_valid = 1'b0;
                        end
                    end
                    KIND_STOP: begin
                        if (slot_ok) begin
                            ctrl.op = OP_REMOVE;
                            del_v   = pre_match;
                        end
                    end
                    KIND_ADVANCE: begin
                        ctrl.op   = OP_ADVANCE;
                        n_state   = ST_EMIT;
                        n_o_valid = 1'b0;
                    end
                    KIND_QUERY: begin
                        n_o_kind = OK_QUERY;
                        if (ent[0].valid) begin
                            n_o_present = 1'b1;
                            n_o_ticks   = OUT_TICK_W'(tk[0]);
                        end
                    end
                    KIND_SERVICE: begin
                        n_o_kind = OK_SERVICE;
                        if (ent[0].valid && (tk[0] == '0)) begin
                            ctrl.op     = OP_REMOVE;
                            del_v       = '1;
                            n_o_present = 1'b1;
                            n_o_timer   = ent[0].timer;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_INSERT: begin
                if (!ent[LAST].valid) begin
                    ctrl.op = OP_INSERT;
                end
                n_o_valid = 1'b1;
                n_o_last  = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_EMIT: begin
                n_o_valid = 1'b1;
                if (scan[0].flag) begin
                    ctrl.op     = OP_SCAN;
                    n_o_kind    = OK_EVENT;
                    n_o_handler = scan[0].handler;
                    n_o_timer   = scan[0].timer;
                end else begin
                    n_o_last = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_kind    <= i_kind;
            r_slot    <= i_timer_slot;
            r_handler <= i_handler;
            r_ticks   <= i_tick_count[TICK_BITS-1:0];
        end
        r_o_kind    <= n_o_kind;
        r_o_handler <= n_o_handler;
        r_o_timer   <= n_o_timer;
        r_o_present <= n_o_present;
        r_o_ticks   <= n_o_ticks;
        r_o_last    <= n_o_last;
    end

    assign o_valid           = r_o_valid;
    assign o_out_kind        = r_o_kind;
    assign o_event_handler   = r_o_handler;
    assign o_out_timer       = r_o_timer;
    assign o_present         = r_o_present;
    assign o_remaining_ticks = r_o_ticks;
    assign o_last            = r_o_last;

    a_beat_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != ST_IDLE))
        else $error("result beat without a command in progress");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid_v >> 1) & ~valid_v) == '0)
        else $error("queue cells not a contiguous prefix");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("still busy after final result beat");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted command");

endmodule

@@ design/stq_cell.sv @@
module stq_cell #(
    parameter int TICK_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stq_pkg::t_cell_ctrl  i_ctrl,
    input  logic [TICK_BITS-1:0] i_ticks,
    input  logic                 i_del,
    input  stq_pkg::t_entry      i_left,
    input  logic [TICK_BITS-1:0] i_left_ticks,
    input  logic                 i_left_ge,
    input  stq_pkg::t_entry      i_right,
    input  logic [TICK_BITS-1:0] i_right_ticks,
    input  stq_pkg::t_scan       i_right_scan,
    output stq_pkg::t_entry      o_entry,
    output logic [TICK_BITS-1:0] o_ticks,
    output logic                 o_ge,
    output logic                 o_match,
    output stq_pkg::t_scan       o_scan
);
    import stq_pkg::*;

    logic                 r_valid, n_valid;
    logic [SLOT_W-1:0]    r_timer, n_timer;
    logic [HND_W-1:0]     r_handler, n_handler;
    logic [TICK_BITS-1:0] r_ticks, n_ticks;
    t_scan                r_scan, n_scan;
    logic [TICK_BITS-1:0] sub_ticks;

    assign o_entry = '{valid: r_valid, timer: r_timer, handler: r_handler};
    assign o_ticks = r_ticks;
    assign o_ge    = r_valid && (i_ticks >= r_ticks);
    assign o_match = r_valid && (r_timer == i_ctrl.slot);
    assign o_scan  = r_scan;

    assign sub_ticks = (i_ticks < r_ticks) ? (r_ticks - i_ticks) : '0;

    always_comb begin
        n_valid   = r_valid;
        n_timer   = r_timer;
        n_handler = r_handler;
        n_ticks   = r_ticks;
        n_scan    = r_scan;
        unique case (i_ctrl.op)
            OP_REMOVE: begin
                if (i_del) begin
                    n_valid   = i_right.valid;
                    n_timer   = i_right.timer;
                    n_handler = i_right.handler;
                    n_ticks   = i_right_ticks;
                end
            end
            OP_INSERT: begin
                if (!o_ge) begin
                    if (i_left_ge) begin
                        n_valid   = 1'b1;
                        n_timer   = i_ctrl.slot;
                        n_handler = i_ctrl.handler;
                        n_ticks   = i_ticks;
                    end else begin
                        n_valid   = i_left.valid;
                        n_timer   = i_left.timer;
                        n_handler = i_left.handler;
                        n_ticks   = i_left_ticks;
                    end
                end
            end
            OP_ADVANCE: begin
                n_ticks = sub_ticks;
                n_scan  = '{flag: r_valid && (sub_ticks == '0), timer: r_timer,
                            handler: r_handler};
            end
            OP_SCAN: begin
                n_scan = i_right_scan;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_scan.flag <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_scan.flag <= n_scan.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_timer        <= n_timer;
        r_handler      <= n_handler;
        r_ticks        <= n_ticks;
        r_scan.timer   <= n_scan.timer;
        r_scan.handler <= n_scan.handler;
    end

endmodule

@@ tb/tb_sorted_software_timer_queue.sv @@
`timescale 1ns / 1ps

module tb_sorted_software_timer_queue;
    import stq_pkg::*;

    localparam int TIMER_SLOTS    = 16;
    localparam int TICK_BITS      = 32;
    localparam int RANDOM_BEATS   = 120;
    localparam int TAIL_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

    typedef struct packed {
        logic [OKIND_W-1:0]    kind;
        logic [HND_W-1:0]      hnd;
        logic [SLOT_W-1:0]     tmr;
        logic                  present;
        logic [OUT_TICK_W-1:0] ticks;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_W-1:0]     slot;
        logic [HND_W-1:0]      hnd;
        logic [OUT_TICK_W-1:0] ticks;
        logic                  typed;
        t_result               want;
    } t_stim;

    localparam t_result DONE_RES      = '{OK_DONE, 8'd0, 4'd0, 1'b0, 32'd0, 1'b1};
    localparam t_result EMPTY_QUERY   = '{OK_QUERY, 8'd0, 4'd0, 1'b0, 32'd0, 1'b1};
    localparam t_result EMPTY_SERVICE = '{OK_SERVICE, 8'd0, 4'd0, 1'b0, 32'd0, 1'b1};
    localparam t_result NO_TYPED      = '0;

    localparam int DIRECTED_ROWS = 22;
    localparam t_stim DIRECTED [DIRECTED_ROWS] = '{
        '{KIND_QUERY,   4'd0, 8'h00, 32'd0,         1'b1, EMPTY_QUERY},
        '{KIND_SERVICE, 4'd9, 8'hFF, 32'hFFFFFFFF,  1'b1, EMPTY_SERVICE},
        '{KIND_BAD_LO,  4'd0, 8'h00, 32'd0,         1'b1, DONE_RES},
        '{KIND_BAD_HI,  4'hF, 8'hFF, 32'hFFFFFFFF,  1'b1, DONE_RES},
        '{KIND_STOP,    4'd3, 8'h00, 32'd0,         1'b1, DONE_RES},
        '{KIND_ADVANCE, 4'd0, 8'h00, 32'd7,         1'b1, DONE_RES},
        '{KIND_START,   4'd0, 8'hFF, 32'hFFFFFFFF,  1'b1, DONE_RES},
        '{KIND_START,   4'hF, 8'h00, 32'd0,         1'b1, DONE_RES},
        '{KIND_START,   4'd5, 8'hA5, 32'd100,       1'b0, NO_TYPED},
        '{KIND_START,   4'd6, 8'h5A, 32'd100,       1'b0, NO_TYPED},
        '{KIND_QUERY,   4'd0, 8'h00, 32'd0,         1'b0, NO_TYPED},
        '{KIND_SERVICE, 4'd0, 8'h00, 32'd0,         1'b0, NO_TYPED},
        '{KIND_ADVANCE, 4'd0, 8'h00, 32'd0,         1'b0, NO_TYPED},
        '{KIND_START,   4'd5, 8'h3C, 32'd50,        1'b0, NO_TYPED},
        '{KIND_ADVANCE, 4'd0, 8'h00, 32'd60,        1'b0, NO_TYPED},
        '{KIND_ADVANCE, 4'd0, 8'h00, 32'd0,         1'b0, NO_TYPED},
        '{KIND_SERVICE, 4'd0, 8'h00, 32'd0,         1'b0, NO_TYPED},
        '{KIND_STOP,    4'd6, 8'h00, 32'd0,         1'b0, NO_TYPED},
        '{KIND_ADVANCE, 4'd0, 8'h00, 32'hFFFFFFFF,  1'b0, NO_TYPED},
        '{KIND_QUERY,   4'd0, 8'h00, 32'd0,         1'b0, NO_TYPED},
        '{KIND_SERVICE, 4'd0, 8'h00, 32'd0,         1'b0, NO_TYPED},
        '{KIND_SERVICE, 4'd0, 8'h00, 32'd0,         1'b0, NO_TYPED}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [KIND_W-1:0]     i_kind = '0;
    logic [SLOT_W-1:0]     i_timer_slot = '0;
    logic [HND_W-1:0]      i_handler = '0;
    logic [OUT_TICK_W-1:0] i_tick_count = '0;
    logic                  o_valid;
    logic [OKIND_W-1:0]    o_out_kind;
    logic [HND_W-1:0]      o_event_handler;
    logic [SLOT_W-1:0]     o_out_timer;
    logic                  o_present;
    logic [OUT_TICK_W-1:0] o_remaining_ticks;
    logic                  o_last;

    logic                  q_valid   [TIMER_SLOTS];
    logic [SLOT_W-1:0]     q_timer   [TIMER_SLOTS];
    logic [OUT_TICK_W-1:0] q_ticks   [TIMER_SLOTS];
    logic [HND_W-1:0]      q_handler [TIMER_SLOTS];
    logic                  slot_running [TIMER_SLOTS];

    t_result pending_results[$];
    t_result fresh_results[$];

    int idle_pct = 15;
    int fail_count = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int ready_events = 0;
    int timers_popped = 0;
    int quiet_cycles = 0;

    sorted_software_timer_queue #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TICK_BITS   (TICK_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_timer_slot      (i_timer_slot),
        .i_handler         (i_handler),
        .i_tick_count      (i_tick_count),
        .o_valid           (o_valid),
        .o_out_kind        (o_out_kind),
        .o_event_handler   (o_event_handler),
        .o_out_timer       (o_out_timer),
        .o_present         (o_present),
        .o_remaining_ticks (o_remaining_ticks),
        .o_last            (o_last)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_result make_result(input logic [OKIND_W-1:0] kind,
                                            input logic [HND_W-1:0] hnd,
                                            input logic [SLOT_W-1:0] tmr,
                                            input logic present,
                                            input logic [OUT_TICK_W-1:0] ticks,
                                            input logic last);
        t_result r;
        r.kind    = kind;
        r.hnd     = hnd;
        r.tmr     = tmr;
        r.present = present;
        r.ticks   = ticks;
        r.last    = last;
        return r;
    endfunction

    function automatic int unsigned queue_depth();
        int unsigned n;
        n = 0;
        while (n < TIMER_SLOTS && q_valid[n])
            n++;
        return n;
    endfunction

    function automatic void drop_cell(input int unsigned pos);
        int unsigned n;
        n = queue_depth();
        if (pos >= n)
            return;
        for (int unsigned i = pos; i + 1 < n; i++) begin
            q_timer[i]   = q_timer[i + 1];
            q_ticks[i]   = q_ticks[i + 1];
            q_handler[i] = q_handler[i + 1];
        end
        q_valid[n - 1] = 1'b0;
    endfunction

    function automatic void drop_timer(input logic [SLOT_W-1:0] slot);
        int unsigned n;
        n = queue_depth();
        for (int unsigned i = 0; i < n; i++) begin
            if (q_timer[i] == slot) begin
                drop_cell(i);
                slot_running[slot] = 1'b0;
                return;
            end
        end
    endfunction

    function automatic void timer_queue_step(input logic [KIND_W-1:0] kind,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [HND_W-1:0] hnd,
                                             input logic [OUT_TICK_W-1:0] ticks);
        int unsigned n;
        int unsigned pos;
        logic [SLOT_W-1:0] popped;
        fresh_results.delete();
        case (kind)
            KIND_START: begin
                if (slot < TIMER_SLOTS) begin
                    if (slot_running[slot])
                        drop_timer(slot);
                    n = queue_depth();
                    if (n < TIMER_SLOTS) begin
                        pos = 0;
                        while (pos < n && ticks >= q_ticks[pos])
                            pos++;
                        for (int unsigned i = n; i > pos; i--) begin
                            q_timer[i]   = q_timer[i - 1];
                            q_ticks[i]   = q_ticks[i - 1];
                            q_handler[i] = q_handler[i - 1];
                        end
                        q_timer[pos]       = slot;
                        q_ticks[pos]       = ticks;
                        q_handler[pos]     = hnd;
                        q_valid[n]         = 1'b1;
                        slot_running[slot] = 1'b1;
                    end
                end
                fresh_results.push_back(DONE_RES);
            end
            KIND_STOP: begin
                if (slot < TIMER_SLOTS)
                    drop_timer(slot);
                fresh_results.push_back(DONE_RES);
            end
            KIND_ADVANCE: begin
                n = queue_depth();
                for (int unsigned i = 0; i < n; i++) begin
                    if (ticks < q_ticks[i]) begin
                        q_ticks[i] = q_ticks[i] - ticks;
                    end else begin
                        q_ticks[i] = '0;
                        fresh_results.push_back(make_result(OK_EVENT, q_handler[i],
                                                            q_timer[i], 1'b0, '0, 1'b0));
                    end
                end
                fresh_results.push_back(DONE_RES);
            end
            KIND_QUERY: begin
                if (q_valid[0])
                    fresh_results.push_back(make_result(OK_QUERY, '0, '0, 1'b1,
                                                        q_ticks[0], 1'b1));
                else
                    fresh_results.push_back(EMPTY_QUERY);
            end
            KIND_SERVICE: begin
                if (q_valid[0] && q_ticks[0] == '0) begin
                    popped = q_timer[0];
                    drop_cell(0);
                    slot_running[popped] = 1'b0;
                    fresh_results.push_back(make_result(OK_SERVICE, '0, popped, 1'b1,
                                                        '0, 1'b1));
                end else begin
                    fresh_results.push_back(EMPTY_SERVICE);
                end
            end
            default: begin
                fresh_results.push_back(DONE_RES);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic send_beat(input logic [KIND_W-1:0] kind,
                             input logic [SLOT_W-1:0] slot,
                             input logic [HND_W-1:0] hnd,
                             input logic [OUT_TICK_W-1:0] ticks,
                             input logic typed,
                             input t_result want);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_kind       <= kind;
        i_timer_slot <= slot;
        i_handler    <= hnd;
        i_tick_count <= ticks;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        timer_queue_step(kind, slot, hnd, ticks);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (fresh_results[i])
                pending_results.push_back(fresh_results[i]);
        beats_sent++;
    endtask

    task automatic random_beat();
        logic [KIND_W-1:0]     kind;
        logic [OUT_TICK_W-1:0] ticks;
        int pick;
        pick  = $urandom_range(99);
        ticks = $urandom;
        if (pick < 36) begin
            kind = KIND_START;
            case ($urandom_range(9)) inside
                [0:5]:   ticks = $urandom_range(60);
                [6:7]:   ticks = 20 * $urandom_range(2);
                8:       ticks = $urandom;
                default: ticks = 32'hFFFFFFF0 | $urandom_range(15);
            endcase
        end else if (pick < 46) begin
            kind = KIND_STOP;
        end else if (pick < 68) begin
            kind = KIND_ADVANCE;
            case ($urandom_range(9)) inside
                [0:6]:   ticks = $urandom_range(25);
                7:       ticks = '0;
                8:       ticks = $urandom;
                default: ticks = 32'hFFFFFFFF;
            endcase
        end else if (pick < 78) begin
            kind = KIND_QUERY;
        end else if (pick < 95) begin
            kind = KIND_SERVICE;
        end else begin
            kind = KIND_W'($urandom_range(KIND_BAD_HI, KIND_BAD_LO));
        end
        send_beat(kind, SLOT_W'($urandom_range(TIMER_SLOTS - 1)),
                  HND_W'($urandom_range(255)), ticks, 1'b0, NO_TYPED);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_out_kind == OK_EVENT)
                ready_events++;
            if (o_out_kind == OK_SERVICE && o_present)
                timers_popped++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, kind", 32'(o_out_kind), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_kind !== want.kind)
                    report_mismatch("out_kind", 32'(o_out_kind), 32'(want.kind));
                if (o_event_handler !== want.hnd)
                    report_mismatch("event_handler", 32'(o_event_handler), 32'(want.hnd));
                if (o_out_timer !== want.tmr)
                    report_mismatch("out_timer", 32'(o_out_timer), 32'(want.tmr));
                if (o_present !== want.present)
                    report_mismatch("present", 32'(o_present), 32'(want.present));
                if (o_remaining_ticks !== want.ticks)
                    report_mismatch("remaining_ticks", o_remaining_ticks, want.ticks);
                if (o_last !== want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat and no result for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            q_valid[i]      = 1'b0;
            q_timer[i]      = '0;
            q_ticks[i]      = '0;
            q_handler[i]    = '0;
            slot_running[i] = 1'b0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_beat(DIRECTED[r].kind, DIRECTED[r].slot, DIRECTED[r].hnd,
                      DIRECTED[r].ticks, DIRECTED[r].typed, DIRECTED[r].want);

        idle_pct = 15;
        repeat (RANDOM_BEATS) random_beat();
        idle_pct = 85;
        repeat (RANDOM_BEATS) random_beat();
        idle_pct = 0;
        repeat (RANDOM_BEATS) random_beat();

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never seen, count", 32'(pending_results.size()), '0);

        $display("covered %0d commands over three idle profiles, %0d results checked",
                 beats_sent, results_seen);
        $display("saw %0d ready events and %0d serviced timers", ready_events,
                 timers_popped);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
